/* hdl/dhfk_pkg.sv */
// Shared constants, types and arithmetic helpers for the arm kinematics pipeline.
package dhfk_pkg;

    localparam int CORDIC_STEPS = 28;
    localparam int CW           = 34;                 // CORDIC x/y/z datapath width
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam int REG_BASE_X = 0;
    localparam int REG_BASE_H = 1;
    localparam int REG_UPPER  = 2;
    localparam int REG_FORE   = 3;
    localparam int REG_TOOL   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic signed [CW-1:0] t_cw;

    typedef struct packed {
        logic signed [15:0] base_x;
        logic signed [15:0] base_h;
        logic [14:0]        upper;
        logic [14:0]        fore;
        logic [14:0]        tool;
    } t_cfg;

    function automatic t_cw atan_of(input int i);
        case (i)
            0:  atan_of = 34'sd536870912;
            1:  atan_of = 34'sd316933406;
            2:  atan_of = 34'sd167458907;
            3:  atan_of = 34'sd85004756;
            4:  atan_of = 34'sd42667331;
            5:  atan_of = 34'sd21354465;
            6:  atan_of = 34'sd10679838;
            7:  atan_of = 34'sd5340245;
            8:  atan_of = 34'sd2670163;
            9:  atan_of = 34'sd1335087;
            10: atan_of = 34'sd667544;
            11: atan_of = 34'sd333772;
            12: atan_of = 34'sd166886;
            13: atan_of = 34'sd83443;
            14: atan_of = 34'sd41722;
            15: atan_of = 34'sd20861;
            16: atan_of = 34'sd10430;
            17: atan_of = 34'sd5215;
            18: atan_of = 34'sd2608;
            19: atan_of = 34'sd1304;
            20: atan_of = 34'sd652;
            21: atan_of = 34'sd326;
            22: atan_of = 34'sd163;
            23: atan_of = 34'sd81;
            24: atan_of = 34'sd41;
            25: atan_of = 34'sd20;
            26: atan_of = 34'sd10;
            27: atan_of = 34'sd5;
            default: atan_of = '0;
        endcase
    endfunction

endpackage

/* hdl/dhfk_if.sv */
// Valid/ready stream interface carrying one packed payload.
interface dhfk_if #(
    parameter int W = 1
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/dhfk_cfg_if.sv */
// Configuration write channel: register index and write data.
interface dhfk_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [dhfk_pkg::CFG_IDX_W-1:0]      index;
    logic [dhfk_pkg::CFG_DATA_W-1:0]     wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

/* hdl/dhfk_cordic.sv */
// Pipelined rotation-mode CORDIC producing cosine and sine in Q30, one stage per step.
module dhfk_cordic (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [31:0]            i_phase,
    output dhfk_pkg::t_cw          o_cos,
    output dhfk_pkg::t_cw          o_sin
);
    localparam int N = dhfk_pkg::CORDIC_STEPS;

    dhfk_pkg::t_cw r_x [N+1];
    dhfk_pkg::t_cw r_y [N+1];
    dhfk_pkg::t_cw r_z [N+1];
    logic          r_flip [N+1];

    logic [31:0] n_q;
    logic        n_flip;

    assign n_flip = i_phase[31] ^ i_phase[30];
    assign n_q    = n_flip ? (i_phase + 32'h8000_0000) : i_phase;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= dhfk_pkg::CORDIC_GAIN;
            r_y[0]    <= '0;
            r_z[0]    <= dhfk_pkg::t_cw'($signed(n_q));
            r_flip[0] <= n_flip;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_step
        dhfk_pkg::t_cw dx, dy;
        assign dx = r_y[g] >>> g;
        assign dy = r_x[g] >>> g;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_flip[g+1] <= r_flip[g];
                if (!r_z[g][dhfk_pkg::CW-1]) begin
                    r_x[g+1] <= r_x[g] - dx;
                    r_y[g+1] <= r_y[g] + dy;
                    r_z[g+1] <= r_z[g] - dhfk_pkg::atan_of(g);
                end else begin
                    r_x[g+1] <= r_x[g] + dx;
                    r_y[g+1] <= r_y[g] - dy;
                    r_z[g+1] <= r_z[g] + dhfk_pkg::atan_of(g);
                end
            end
        end
    end

    assign o_cos = r_flip[N] ? -r_x[N] : r_x[N];
    assign o_sin = r_flip[N] ? -r_y[N] : r_y[N];
endmodule

/* hdl/dhfk_chain.sv */
// Link-length products, reach rounding, yaw projection and saturation stages.
module dhfk_chain #(
    parameter int COORD_BITS = 17
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  dhfk_pkg::t_cfg         i_cfg,
    input  dhfk_pkg::t_cw          i_cy,
    input  dhfk_pkg::t_cw          i_sy,
    input  dhfk_pkg::t_cw          i_c1,
    input  dhfk_pkg::t_cw          i_s1,
    input  dhfk_pkg::t_cw          i_c2,
    input  dhfk_pkg::t_cw          i_s2,
    input  dhfk_pkg::t_cw          i_c3,
    input  dhfk_pkg::t_cw          i_s3,
    output logic [3*COORD_BITS:0]  o_res
);
    localparam int PW = 52;
    localparam int SW = 54;
    localparam int RW = 32;
    localparam int MW = 74;
    localparam int OW = 76;
    localparam logic signed [OW-1:0] HI = OW'((64'sd1 <<< (COORD_BITS-1)) - 1);
    localparam logic signed [OW-1:0] LO = -OW'(64'sd1 <<< (COORD_BITS-1));

    // stage A: six link products
    logic signed [PW-1:0] r_pc1, r_pc2, r_pc3, r_ps1, r_ps2, r_ps3;
    dhfk_pkg::t_cw        r_cya, r_sya;
    // stage B: sums
    logic signed [SW-1:0] r_reach, r_sum;
    dhfk_pkg::t_cw        r_cyb, r_syb;
    // stage C: rounded reach, fits 32 bits signed
    logic signed [RW-1:0] r_r14;
    logic signed [OW-1:0] r_zc;
    dhfk_pkg::t_cw        r_cyc, r_syc;
    // stage D: yaw products
    logic signed [MW-1:0] r_mx, r_my;
    logic signed [OW-1:0] r_zd;
    // stage E: final
    logic [3*COORD_BITS:0] r_res;

    logic signed [SW-1:0] n_r;
    logic signed [63:0]   n_mx, n_my;
    logic signed [OW-1:0] n_x, n_y, n_z;
    logic                 n_cx, n_cy, n_cz;
    logic [COORD_BITS-1:0] n_xs, n_ys, n_zs;

    function automatic logic signed [PW-1:0] mul_len(input logic [14:0] l, input dhfk_pkg::t_cw v);
        mul_len = PW'($signed({1'b0, l}) * v);
    endfunction

    function automatic logic [COORD_BITS-1:0] sat(input logic signed [OW-1:0] v,
                                                  output logic clip);
        clip = (v > HI) || (v < LO);
        if (v > HI)      sat = HI[COORD_BITS-1:0];
        else if (v < LO) sat = LO[COORD_BITS-1:0];
        else             sat = v[COORD_BITS-1:0];
    endfunction

    assign n_r = r_reach + (SW'(1) <<< 15);

    // cos/sin stay within 32 bits signed
    assign n_mx = $signed(r_cyc[31:0]) * r_r14;
    assign n_my = $signed(r_syc[31:0]) * r_r14;

    always_comb begin
        n_x = OW'(i_cfg.base_x) + OW'((r_mx + (MW'(1) <<< 43)) >>> 44);
        n_y = OW'((r_my + (MW'(1) <<< 43)) >>> 44);
        n_z = r_zd;
        n_xs = sat(n_x, n_cx);
        n_ys = sat(n_y, n_cy);
        n_zs = sat(n_z, n_cz);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pc1 <= mul_len(i_cfg.upper, i_c1);
            r_pc2 <= mul_len(i_cfg.fore,  i_c2);
            r_pc3 <= mul_len(i_cfg.tool,  i_c3);
            r_ps1 <= mul_len(i_cfg.upper, i_s1);
            r_ps2 <= mul_len(i_cfg.fore,  i_s2);
            r_ps3 <= mul_len(i_cfg.tool,  i_s3);
            r_cya <= i_cy;
            r_sya <= i_sy;

            r_reach <= SW'(r_pc1) + SW'(r_pc2) + SW'(r_pc3);
            r_sum   <= SW'(r_ps1) + SW'(r_ps2) + SW'(r_ps3);
            r_cyb   <= r_cya;
            r_syb   <= r_sya;

            r_r14 <= RW'(n_r >>> 16);
            r_zc  <= OW'(i_cfg.base_h) - OW'((r_sum + (SW'(1) <<< 29)) >>> 30);
            r_cyc <= r_cyb;
            r_syc <= r_syb;

            r_mx <= MW'(n_mx);
            r_my <= MW'(n_my);
            r_zd <= r_zc;

            r_res <= {n_cx | n_cy | n_cz, n_zs, n_ys, n_xs};
        end
    end

    assign o_res = r_res;
endmodule

/* hdl/dh_forward_kinematics_4dof.sv */
// Top level: four-joint arm tool-tip position, fully pipelined.
// Usage:
//   i_cfg: write channel, index 0 base x offset, 1 base height, 2 upper arm,
//   3 forearm, 4 tool length; always ready; unknown indexes are ignored.
//   Write only while the pipeline is empty.
//   i_in: one beat holds yaw, shoulder, elbow and wrist angles (binary angles).
//   o_out: one beat holds tip x, y, z (2^-16 m, saturated) and the clip flag.
// Throughput: one beat per cycle while o_out is not stalled. Pipeline: an angle sum stage,
//   29 CORDIC stages and 5 product and saturation stages from acceptance to o_out valid,
//   all moving together on one pipeline enable.
// Stall: the whole pipeline advances when the output slot is empty or taken;
//   a held output freezes every stage, nothing is lost or repeated.
// Reset clears all valid bits and restores the register defaults.
module dh_forward_kinematics_4dof #(
    parameter int ANGLE_BITS = 16,
    parameter int COORD_BITS = 17
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dhfk_cfg_if.sink   i_cfg,
    dhfk_if.sink       i_in,
    dhfk_if.source     o_out
);
    localparam int LAT = dhfk_pkg::CORDIC_STEPS + 7;

    dhfk_pkg::t_cfg r_cfg;
    logic [LAT-1:0] r_vld;
    logic           w_en;
    logic [31:0]    w_ph [4];
    logic [31:0]    r_py, r_p1, r_p2, r_p3;
    dhfk_pkg::t_cw  w_c [4];
    dhfk_pkg::t_cw  w_s [4];

    assign w_en        = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready  = w_en;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_vld[LAT-1];

    for (genvar g = 0; g < 4; g++) begin : g_ph
        assign w_ph[g] = {i_in.data[g*ANGLE_BITS +: ANGLE_BITS], {(32-ANGLE_BITS){1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_cfg <= '{base_x: -16'sd1068, base_h: 16'sd4677,
                       upper: 15'd5440, fore: 15'd6095, tool: 15'd5297};
        end else begin
            if (w_en) r_vld <= {r_vld[LAT-2:0], i_in.valid};
            if (i_cfg.valid) begin
                case (int'(i_cfg.index))
                    dhfk_pkg::REG_BASE_X: r_cfg.base_x <= i_cfg.wdata;
                    dhfk_pkg::REG_BASE_H: r_cfg.base_h <= i_cfg.wdata;
                    dhfk_pkg::REG_UPPER:  r_cfg.upper  <= i_cfg.wdata[14:0];
                    dhfk_pkg::REG_FORE:   r_cfg.fore   <= i_cfg.wdata[14:0];
                    dhfk_pkg::REG_TOOL:   r_cfg.tool   <= i_cfg.wdata[14:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_py <= w_ph[0];
            r_p1 <= w_ph[1];
            r_p2 <= w_ph[1] + w_ph[2];
            r_p3 <= w_ph[1] + w_ph[2] + w_ph[3];
        end
    end

    dhfk_cordic u_cy (.i_clk, .i_en(w_en), .i_phase(r_py), .o_cos(w_c[0]), .o_sin(w_s[0]));
    dhfk_cordic u_c1 (.i_clk, .i_en(w_en), .i_phase(r_p1), .o_cos(w_c[1]), .o_sin(w_s[1]));
    dhfk_cordic u_c2 (.i_clk, .i_en(w_en), .i_phase(r_p2), .o_cos(w_c[2]), .o_sin(w_s[2]));
    dhfk_cordic u_c3 (.i_clk, .i_en(w_en), .i_phase(r_p3), .o_cos(w_c[3]), .o_sin(w_s[3]));

    dhfk_chain #(.COORD_BITS(COORD_BITS)) u_chain (
        .i_clk, .i_en(w_en), .i_cfg(r_cfg),
        .i_cy(w_c[0]), .i_sy(w_s[0]), .i_c1(w_c[1]), .i_s1(w_s[1]),
        .i_c2(w_c[2]), .i_s2(w_s[2]), .i_c3(w_c[3]), .i_s3(w_s[3]),
        .o_res(o_out.data)
    );
endmodule

/* hdl/dhfk_checker.sv */
// Port-level checker for the kinematics block, bound to the top level.
module dhfk_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic cfg_ready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("output beat dropped");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |-> !in_ready) else $error("input taken during stall");
    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_valid |-> in_ready) else $error("input blocked with empty output");
    a_cfg: assert property (@(posedge i_clk) cfg_ready) else $error("config not ready");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !out_valid)
        else $error("output valid after reset");
endmodule

bind dh_forward_kinematics_4dof dhfk_checker u_chk (
    .i_clk, .i_rst_n,
    .in_ready(i_in.ready),
    .out_valid(o_out.valid), .out_ready(o_out.ready),
    .cfg_ready(i_cfg.ready)
);
